// File: sv/free_list_slot_store_defines.svh
// assertion macros shared by the free-list slot store rtl
// depends on a clock named clk and a synchronous active-high reset named rst
`ifndef FREE_LIST_SLOT_STORE_DEFINES_SVH
`define FREE_LIST_SLOT_STORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FLS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot store check failed");

// next-cycle implication, checked outside reset
`define FLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot store check failed");

`endif

// File: sv/fls_pkg.sv
// constants, codes and item layout for the free-list slot store
// no dependencies
`default_nettype none

package fls_pkg;

  // store geometry
  localparam int DEPTH        = 128;
  localparam int PAYLOAD_BITS = 64;
  localparam int IDX_BITS     = $clog2(DEPTH);
  localparam int LINK_BITS    = $clog2(DEPTH + 1);

  // link code for an empty list or the end of the chain
  localparam logic [LINK_BITS-1:0] LINK_NONE = LINK_BITS'(DEPTH);

  // item field widths
  localparam int OPCODE_W  = 3;
  localparam int SLOT_IN_W = 8;
  localparam int DATA_W    = 64;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 7;

  // stream widths, padded to whole bytes
  localparam int IN_BITS   = OPCODE_W + SLOT_IN_W + DATA_W;
  localparam int OUT_BITS  = STATUS_W + SLOT_W + DATA_W;
  localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 3'd0,
    OP_FREE   = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: sv/free_list_slot_store.sv
// Free-list slot store: how it is used.
// One input stream (s_tvalid/s_tready/s_tdata) carries operations: insert,
// free, read, write and clear. Every operation yields exactly one result item
// on the output stream (m_tvalid/m_tready/m_tdata) with status, slot and
// payload. Insert pops the head of the free list, free pushes a slot back,
// read and write access a slot's payload, clear relinks every slot.
// Each item is latched at accept, when the link and payload memories are
// read into registers; in the update step the memories, the head register
// and the output register are written. The next item is accepted only once
// the last one has been through its update. Clear follows the same steps:
// the link memory is backed by per-entry valid bits that clear at once, an
// invalid entry reading as its initial link i+1.
// Reset: the free list is 0,1,...,DEPTH-1 with slot 0 at the head; payloads
// are undefined until written. No clearing pass follows reset.
// Stall: the result waits in the output register while m_tready is low; the
// next item is still accepted, but its update waits until the output
// register is free.
// depends on fls_pkg and free_list_slot_store_defines.svh
`default_nettype none

`include "free_list_slot_store_defines.svh"

module free_list_slot_store
  import fls_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // opcode [2:0], slot_index [10:3], payload_in [74:11], zero [79:75]
  input  wire logic [IN_TDATA-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // status [1:0], slot_out [8:2], payload_out [72:9], zero [79:73]
  output logic [OUT_TDATA-1:0]      m_tdata
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                  state;
  logic [LINK_BITS-1:0]    head;
  logic [DEPTH-1:0]        link_valid;

  // latched item
  opcode_t                 op_q;
  logic [SLOT_IN_W-1:0]    slot_index_q;
  logic [DATA_W-1:0]       payload_in_q;

  // memories and their registered read data
  logic [LINK_BITS-1:0]    link_mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem  [DEPTH];
  logic [LINK_BITS-1:0]    link_q;
  logic                    link_ok_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  // update cycle signals
  logic                    in_fire;
  logic                    exec_fire;
  logic                    idx_ok;
  logic [IDX_BITS-1:0]     head_idx;
  logic [IDX_BITS-1:0]     slot_idx;
  logic [IDX_BITS-1:0]     rd_slot_idx;
  logic [LINK_BITS-1:0]    head_link;
  logic                    link_we;
  logic [IDX_BITS-1:0]     link_waddr;
  logic [LINK_BITS-1:0]    link_wdata;
  logic                    pay_we;
  logic [IDX_BITS-1:0]     pay_waddr;
  logic                    links_clear;
  logic [LINK_BITS-1:0]    head_next;
  status_t                 status_next;
  logic [SLOT_W-1:0]       slot_next;
  logic [DATA_W-1:0]       payout_next;

  assign s_tready    = (state == S_IDLE);
  assign in_fire     = s_tvalid && s_tready;
  assign exec_fire   = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign head_idx    = IDX_BITS'(head);
  assign slot_idx    = IDX_BITS'(slot_index_q);
  assign rd_slot_idx = IDX_BITS'(s_tdata[10:3]);
  assign idx_ok      = 32'(slot_index_q) < DEPTH;

  // link of the head slot; an untouched entry holds its initial link
  assign head_link = link_ok_q ? link_q : head + LINK_BITS'(1);

  // operation decode for the update cycle
  always_comb begin
    link_we     = 1'b0;
    link_waddr  = head_idx;
    link_wdata  = LINK_NONE;
    pay_we      = 1'b0;
    pay_waddr   = head_idx;
    links_clear = 1'b0;
    head_next   = head;
    status_next = ST_OK;
    slot_next   = '0;
    payout_next = '0;
    case (op_q)
      OP_INSERT: begin
        if (head == LINK_NONE) begin
          status_next = ST_FULL;
        end else begin
          head_next = head_link;
          link_we   = 1'b1;
          pay_we    = 1'b1;
          slot_next = SLOT_W'(head);
        end
      end
      OP_FREE: begin
        if (!idx_ok) begin
          status_next = ST_BAD;
        end else begin
          link_we    = 1'b1;
          link_waddr = slot_idx;
          link_wdata = head;
          head_next  = LINK_BITS'(slot_index_q);
        end
      end
      OP_READ: begin
        if (!idx_ok) status_next = ST_BAD;
        else payout_next = DATA_W'(pay_q);
      end
      OP_WRITE: begin
        if (!idx_ok) begin
          status_next = ST_BAD;
        end else begin
          pay_we    = 1'b1;
          pay_waddr = slot_idx;
        end
      end
      OP_CLEAR: begin
        links_clear = 1'b1;
        head_next   = '0;
      end
      default: begin
      end
    endcase
  end

  // link and payload memories, registered read at accept
  always_ff @(posedge clk) begin
    if (exec_fire && link_we) link_mem[link_waddr] <= link_wdata;
    if (exec_fire && pay_we) pay_mem[pay_waddr] <= payload_in_q[PAYLOAD_BITS-1:0];
    if (in_fire) begin
      link_q <= link_mem[head_idx];
      pay_q  <= pay_mem[rd_slot_idx];
    end
  end

  // item latch, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q         <= opcode_t'(s_tdata[2:0]);
      slot_index_q <= s_tdata[10:3];
      payload_in_q <= s_tdata[74:11];
      link_ok_q    <= link_valid[head_idx];
    end
  end

  // control state, free head, valid bits and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      link_valid <= '0;
      m_tvalid   <= 1'b0;
      m_tdata    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          // a waiting result may leave while the next item comes in
          if (m_tvalid && m_tready) m_tvalid <= 1'b0;
          if (in_fire) state <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_fire) begin
            state    <= S_IDLE;
            head     <= head_next;
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_TDATA'({payout_next, slot_next, status_next});
            if (links_clear) link_valid <= '0;
            else if (link_we) link_valid[link_waddr] <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `FLS_ASSERT_NEXT(a_accept_blocks, in_fire, !s_tready)
  `FLS_ASSERT_NOW(a_head_range, 1'b1, head <= LINK_NONE)
  `FLS_ASSERT_NOW(a_error_zero, m_tvalid && m_tdata[1:0] != ST_OK, m_tdata[72:2] == '0)
  `FLS_ASSERT_NEXT(a_insert_slot,
    exec_fire && op_q == OP_INSERT && head != LINK_NONE,
    m_tdata[8:2] == SLOT_W'($past(head)) && m_tdata[1:0] == ST_OK)
  `FLS_ASSERT_NEXT(a_clear_head, exec_fire && op_q == OP_CLEAR,
    head == '0 && link_valid == '0)

endmodule

`default_nettype wire
